### sv/pnt_pkg.sv
`timescale 1ns / 1ps

package pnt_pkg;

    // width of the reported divisor sum
    localparam int SUM_BITS = 19;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_ACC,
        S_FIN
    } t_pnt_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic acc_step;
        logic out_load;
    } t_pnt_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic d_gt_half;
        logic div_last;
    } t_pnt_sts;

endpackage

### sv/pnt_ctrl.sv
`timescale 1ns / 1ps

module pnt_ctrl import pnt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    output logic     o_valid,
    input  logic     i_stall,
    input  t_pnt_sts i_sts,
    output t_pnt_cmd o_cmd
);

    t_pnt_state r_state, n_state;
    logic       r_out_valid, n_out_valid;

    // state and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.d_gt_half) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc_step = 1'b1;
                n_state        = S_CHECK;
            end
            S_FIN: begin
                // wait until the output register is free or being taken
                if (!r_out_valid || !i_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output word valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

### sv/pnt_dp.sv
`timescale 1ns / 1ps

module pnt_dp import pnt_pkg::*; #(
    parameter int NUMBER_BITS = 16
) (
    input  logic                   i_clk,
    input  logic [NUMBER_BITS-1:0] i_number,
    input  t_pnt_cmd               i_cmd,
    output t_pnt_sts               o_sts,
    output logic                   o_is_perfect,
    output logic [SUM_BITS-1:0]    o_divisor_sum
);

    // aliquot sum stays below 32 * n; keep at least one bit above the output
    localparam int ACC_BITS = (NUMBER_BITS + 5 > SUM_BITS + 1) ? NUMBER_BITS + 5
                                                               : SUM_BITS + 1;
    localparam int CNT_BITS = $clog2(NUMBER_BITS);

    logic [NUMBER_BITS-1:0] r_n;
    logic [NUMBER_BITS-1:0] r_half;
    logic [NUMBER_BITS-1:0] r_d;
    logic [NUMBER_BITS-1:0] r_dvd;
    logic [NUMBER_BITS-1:0] r_rem;
    logic [CNT_BITS-1:0]    r_cnt;
    logic [ACC_BITS-1:0]    r_acc;
    logic                   r_is_perfect;
    logic [SUM_BITS-1:0]    r_sum;

    logic [NUMBER_BITS:0]   w_rem_sh;
    logic [NUMBER_BITS:0]   w_rem_sub;
    logic                   w_ge;

    // one restoring division step: shift in next dividend bit, subtract if it fits
    always_comb begin
        w_rem_sh  = {r_rem, r_dvd[NUMBER_BITS-1]};
        w_ge      = (w_rem_sh >= {1'b0, r_d});
        w_rem_sub = w_rem_sh - {1'b0, r_d};
    end

    // trial divisor loop registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n    <= i_number;
            r_half <= i_number >> 1;
            r_d    <= NUMBER_BITS'(1);
            r_acc  <= '0;
        end
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_dvd <= r_n;
            r_cnt <= CNT_BITS'(NUMBER_BITS - 1);
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_rem_sub[NUMBER_BITS-1:0] : w_rem_sh[NUMBER_BITS-1:0];
            r_dvd <= r_dvd << 1;
            r_cnt <= r_cnt - CNT_BITS'(1);
        end
        if (i_cmd.acc_step) begin
            if (r_rem == '0) begin
                r_acc <= r_acc + ACC_BITS'(r_d);
            end
            r_d <= r_d + NUMBER_BITS'(1);
        end
    end

    // result word, sum saturated to the output width
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_is_perfect <= (r_acc == ACC_BITS'(r_n));
            r_sum        <= (|r_acc[ACC_BITS-1:SUM_BITS]) ? {SUM_BITS{1'b1}}
                                                          : r_acc[SUM_BITS-1:0];
        end
    end

    assign o_sts.d_gt_half = (r_d > r_half);
    assign o_sts.div_last  = (r_cnt == '0);
    assign o_is_perfect    = r_is_perfect;
    assign o_divisor_sum   = r_sum;

endmodule

### sv/perfect_number_test.sv
`timescale 1ns / 1ps

// Perfect number test: each input word carries an unsigned number n; the block
// tries every divisor d from 1 to floor(n/2), adds those that divide n exactly
// and returns that aliquot sum (saturated to 19 bits) with a flag set when the
// full sum equals n (0 counts as perfect, 1 does not). Each trial divisor is
// checked by a bit-serial restoring remainder unit, with a compare step before
// it and an accumulate step after it. One number is worked on at a time; the
// next word is taken as soon as the result sits in the output register, even
// if that result is still stalled.
module perfect_number_test import pnt_pkg::*; #(
    parameter int NUMBER_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [NUMBER_BITS-1:0] i_number,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_is_perfect,
    output logic [SUM_BITS-1:0]    o_divisor_sum
);

    t_pnt_cmd w_cmd;
    t_pnt_sts w_sts;

    // sequencer
    pnt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // divisor loop, remainder unit and result register
    pnt_dp #(
        .NUMBER_BITS (NUMBER_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_number      (i_number),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_is_perfect  (o_is_perfect),
        .o_divisor_sum (o_divisor_sum)
    );

endmodule

### sv/pnt_checker.sv
`timescale 1ns / 1ps

module pnt_checker import pnt_pkg::*; #(
    parameter int NUMBER_BITS = 16
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_valid,
    input logic                   o_stall,
    input logic [NUMBER_BITS-1:0] i_number,
    input logic                   o_valid,
    input logic                   i_stall,
    input logic                   o_is_perfect,
    input logic [SUM_BITS-1:0]    o_divisor_sum
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_is_perfect) && $stable(o_divisor_sum))
        else $error("result word changed while stalled");

    // an accepted word makes the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("not busy after accepting a word");

    // busy only starts from an accepted word
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(i_valid))
        else $error("busy without an accepted word");

    // a new result only appears at the end of a busy period
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall) && !o_stall)
        else $error("result appeared outside the end of a busy period");

endmodule

bind perfect_number_test pnt_checker #(
    .NUMBER_BITS (NUMBER_BITS)
) u_pnt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .i_number      (i_number),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_is_perfect  (o_is_perfect),
    .o_divisor_sum (o_divisor_sum)
);

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import pnt_pkg::*;

    localparam int NUMBER_BITS    = 16;
    localparam longint SUM_MAX    = (64'd1 << SUM_BITS) - 1;
    // the watchdog limit lies above the longest busy time of one 16-bit word
    localparam int WATCHDOG_LIMIT = 2_000_000;
    localparam int SETTLE_CYCLES  = 100;
    localparam int RANDOM_WORDS   = 100;
    localparam int IDLE_PCT       = 21;
    localparam int CALM_FROM      = 40;
    localparam int CALM_TO        = 70;

    typedef struct {
        logic [NUMBER_BITS-1:0] number;
        logic                   is_perfect;
        logic [SUM_BITS-1:0]    divisor_sum;
    } t_aliquot;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic [NUMBER_BITS-1:0] i_number = '0;
    logic                   i_stall = 1'b0;
    logic                   o_stall;
    logic                   o_valid;
    logic                   o_is_perfect;
    logic [SUM_BITS-1:0]    o_divisor_sum;

    logic [NUMBER_BITS-1:0] number_q[$];
    t_aliquot               aliquot_q[$];

    int total_words;
    int drain_at;
    int n_sent;
    int n_done_seen;
    int n_got;
    int n_perfect;
    int mismatches;
    int quiet_cycles;
    logic [NUMBER_BITS-1:0] largest = '0;

    perfect_number_test #(
        .NUMBER_BITS(NUMBER_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_number     (i_number),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_is_perfect (o_is_perfect),
        .o_divisor_sum(o_divisor_sum)
    );

    always #10 i_clk = ~i_clk;

    // aliquot sum by trial division, saturated for the output width
    function automatic t_aliquot aliquot_of(input logic [NUMBER_BITS-1:0] number);
        longint unsigned n;
        longint unsigned total;
        longint unsigned d;
        t_aliquot res;
        n     = number;
        total = 0;
        for (d = 1; d <= n / 2; d++) begin
            if (n % d == 0)
                total += d;
        end
        res.number      = number;
        res.is_perfect  = (total == n);
        res.divisor_sum = (total > SUM_MAX) ? SUM_MAX[SUM_BITS-1:0] : total[SUM_BITS-1:0];
        return res;
    endfunction

    task automatic note_failure(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("ERROR: %s", msg);
    endtask

    // driver: presents numbers, predicts each accepted one
    always @(posedge i_clk) begin
        logic hold_off;
        logic idle;
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            i_number <= '0;
        end else begin
            if (o_valid && !i_stall)
                n_done_seen++;
            if (i_valid && !o_stall) begin
                aliquot_q.push_back(aliquot_of(i_number));
                if (i_number > largest)
                    largest = i_number;
                n_sent++;
            end
            if (!i_valid || !o_stall) begin
                // wait for every result once the directed words are in
                hold_off = (n_sent == drain_at) && (n_done_seen < n_sent);
                idle = !(n_sent >= CALM_FROM && n_sent < CALM_TO)
                       && ($urandom_range(0, 99) < IDLE_PCT);
                if (number_q.size() != 0 && !hold_off && !idle) begin
                    i_valid  <= 1'b1;
                    i_number <= number_q.pop_front();
                end else begin
                    i_valid  <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result word against the oldest prediction
    always @(posedge i_clk) begin
        t_aliquot want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (aliquot_q.size() == 0) begin
                    note_failure($sformatf("unexpected word: is_perfect=%0b divisor_sum=%0d",
                                           o_is_perfect, o_divisor_sum));
                end else begin
                    want = aliquot_q.pop_front();
                    if (o_is_perfect !== want.is_perfect
                        || o_divisor_sum !== want.divisor_sum)
                        note_failure($sformatf(
                            "n=%0d: expected is_perfect=%0b sum=%0d, got is_perfect=%0b sum=%0d",
                            want.number, want.is_perfect, want.divisor_sum,
                            o_is_perfect, o_divisor_sum));
                end
                if (o_is_perfect === 1'b1)
                    n_perfect++;
                n_got++;
            end
            if (n_got >= CALM_FROM && n_got < CALM_TO)
                i_stall <= 1'b0;
            else
                i_stall <= ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("perfect_number_test test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus and end of run
    initial begin
        int pick;
        // zero, one, perfect numbers, primes, squares, abundant, all ones
        number_q = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd12,
                     16'd16, 16'd28, 16'd36, 16'd97, 16'd127, 16'd220, 16'd255,
                     16'd256, 16'd496, 16'd945, 16'd1024, 16'd2047, 16'd4095,
                     16'd8128, 16'hffff};
        drain_at = number_q.size();
        // mostly small numbers, as large ones take very long
        for (int k = 0; k < RANDOM_WORDS; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                number_q.push_back(NUMBER_BITS'($urandom_range(0, 255)));
            else if (pick < 95)
                number_q.push_back(NUMBER_BITS'($urandom_range(256, 1023)));
            else
                number_q.push_back(NUMBER_BITS'($urandom_range(1024, 4095)));
        end
        total_words = number_q.size();

        i_rst_n <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk); while (n_sent < total_words);
        do @(negedge i_clk); while (aliquot_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("tested %0d numbers (largest %0d), %0d results flagged perfect",
                 n_sent, largest, n_perfect);
        $display("zero, one, the 16-bit perfect numbers and all-ones input included");
        if (mismatches == 0)
            $display("perfect_number_test test passed");
        else
            $display("perfect_number_test test failed");
        $finish;
    end

endmodule
